// ===== rtl/script_label_line_finder_macros.svh =====
// Assertion macros for the label line finder.
`ifndef SCRIPT_LABEL_LINE_FINDER_MACROS_SVH
`define SCRIPT_LABEL_LINE_FINDER_MACROS_SVH

`ifndef SYNTHESIS
`define SLF_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SLF_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLF_ASSERT(name, clk, rst, prop, msg)
`define SLF_ASSERT_RST(name, clk, prop, msg)
`endif

`endif

// ===== rtl/slf_pkg.sv =====
package slf_pkg;

  localparam int LABEL_BYTES  = 8;
  localparam int LABEL_IDX_W  = (LABEL_BYTES > 1) ? $clog2(LABEL_BYTES) : 1;
  localparam int LABEL_LEN_W  = 4;
  localparam int TEXT_W       = 64;
  localparam int OFFSET_W     = 32;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 1;

  typedef logic [7:0]             byte_t;
  typedef logic [OFFSET_W-1:0]    offset_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic [LABEL_LEN_W-1:0] label_len_t;

  localparam cfg_index_t REG_LABEL_TEXT   = 1'd0;
  localparam cfg_index_t REG_LABEL_LENGTH = 1'd1;

  localparam byte_t CH_NL    = 8'd10;
  localparam byte_t CH_TAB   = 8'd9;
  localparam byte_t CH_SP    = 8'd32;
  localparam byte_t CH_COLON = 8'd58;

endpackage

// ===== rtl/slf_stream_if.sv =====
interface slf_stream_if;
  logic            valid;
  logic            ready;
  slf_pkg::byte_t  stream_byte;
  logic            end_of_stream;

  modport source (output valid, output stream_byte, output end_of_stream, input ready);
  modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

// ===== rtl/slf_result_if.sv =====
interface slf_result_if;
  logic              valid;
  logic              ready;
  logic              label_found;
  slf_pkg::offset_t  resume_offset;

  modport source (output valid, output label_found, output resume_offset, input ready);
  modport sink   (input valid, input label_found, input resume_offset, output ready);
endinterface

// ===== rtl/script_label_line_finder.sv =====
// channel   dir  payload                        beat
// in_ch     in   stream_byte, end_of_stream     valid & ready
// out_ch    out  label_found, resume_offset     valid & ready
// cfg       in   cfg_index, cfg_data            cfg_write
//
// One byte per cycle while in_ch.ready is high; the scan state updates in the
// accepting cycle and a result appears in the output register on the next cycle.
// in_ch.ready drops only while a result waits and out_ch.ready is low.
// rst (synchronous) clears the scan, the label to zero, the length to one.
`include "script_label_line_finder_macros.svh"

module script_label_line_finder (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  slf_pkg::cfg_index_t cfg_index,
  input  slf_pkg::cfg_data_t  cfg_data,
  slf_stream_if.sink          in_ch,
  slf_result_if.source        out_ch
);
  import slf_pkg::*;

  typedef enum logic [1:0] {
    LINE_START,
    AFTER_COLON,
    IN_WORD,
    SKIP_LINE
  } mode_t;

  logic [TEXT_W-1:0] label_text;
  label_len_t        label_length;

  mode_t      mode, mode_next;
  label_len_t word_position, word_position_next;
  logic       word_matches, word_matches_next;
  offset_t    byte_offset, byte_offset_next;

  logic    out_valid;
  logic    out_found;
  offset_t out_offset;

  logic    emit, emit_found;
  offset_t offset_inc;
  byte_t   c;
  logic    blank, newline, length_valid, word_full;
  logic    advance;

  function automatic byte_t label_byte(input logic [TEXT_W-1:0] text,
                                       input logic [LABEL_IDX_W-1:0] idx);
    return text[{idx, 3'b000} +: 8];
  endfunction

  assign c            = in_ch.stream_byte;
  assign blank        = (c == CH_SP) || (c == CH_TAB);
  assign newline      = (c == CH_NL);
  assign length_valid = (label_length != '0) &&
                        (label_length <= LABEL_LEN_W'(LABEL_BYTES));
  assign word_full    = (word_position >= label_length) ||
                        (word_position >= LABEL_LEN_W'(LABEL_BYTES));
  assign offset_inc   = (byte_offset == '1) ? byte_offset : byte_offset + 1'b1;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign advance      = in_ch.valid && in_ch.ready;

  always_comb begin
    mode_next          = mode;
    word_position_next = word_position;
    word_matches_next  = word_matches;
    byte_offset_next   = byte_offset;
    emit               = 1'b0;
    emit_found         = 1'b0;
    if (in_ch.end_of_stream) begin
      emit               = 1'b1;
      mode_next          = LINE_START;
      word_position_next = '0;
      word_matches_next  = 1'b0;
      byte_offset_next   = '0;
    end else begin
      byte_offset_next = offset_inc;
      case (mode)
        LINE_START: begin
          if (!blank && !newline) begin
            if (c == CH_COLON) begin
              mode_next = AFTER_COLON;
            end else begin
              mode_next         = SKIP_LINE;
              word_matches_next = 1'b0;
            end
          end
        end
        AFTER_COLON: begin
          if (!blank) begin
            if (!newline && c == label_byte(label_text, '0)) begin
              mode_next          = IN_WORD;
              word_position_next = LABEL_LEN_W'(1);
              word_matches_next  = length_valid;
            end else begin
              mode_next          = LINE_START;
              word_position_next = '0;
              word_matches_next  = 1'b0;
            end
          end
        end
        IN_WORD: begin
          if (newline || blank) begin
            word_matches_next = word_matches && (word_position == label_length);
            if (blank) begin
              mode_next = SKIP_LINE;
            end else if (word_matches_next) begin
              emit       = 1'b1;
              emit_found = 1'b1;
            end else begin
              mode_next          = LINE_START;
              word_position_next = '0;
              word_matches_next  = 1'b0;
            end
          end else if (word_full) begin
            mode_next         = SKIP_LINE;
            word_matches_next = 1'b0;
          end else begin
            if (c != label_byte(label_text, word_position[LABEL_IDX_W-1:0])) begin
              word_matches_next = 1'b0;
            end
            word_position_next = word_position + 1'b1;
          end
        end
        default: begin
          if (newline) begin
            if (word_matches) begin
              emit       = 1'b1;
              emit_found = 1'b1;
            end else begin
              mode_next          = LINE_START;
              word_position_next = '0;
              word_matches_next  = 1'b0;
            end
          end
        end
      endcase
      if (emit_found) begin
        mode_next          = LINE_START;
        word_position_next = '0;
        word_matches_next  = 1'b0;
        byte_offset_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      label_text    <= '0;
      label_length  <= LABEL_LEN_W'(1);
      mode          <= LINE_START;
      word_position <= '0;
      word_matches  <= 1'b0;
      byte_offset   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_LABEL_TEXT:   label_text   <= cfg_data[TEXT_W-1:0];
          REG_LABEL_LENGTH: label_length <= cfg_data[LABEL_LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        mode          <= mode_next;
        word_position <= word_position_next;
        word_matches  <= word_matches_next;
        byte_offset   <= byte_offset_next;
        if (emit) begin
          out_valid <= 1'b1;
        end
      end
    end
    if (advance && emit) begin
      out_found  <= emit_found;
      out_offset <= emit_found ? offset_inc : '0;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.label_found   = out_found;
  assign out_ch.resume_offset = out_offset;

  `SLF_ASSERT_RST(a_reset_clears_scan, clk,
    rst |=> (mode == LINE_START && byte_offset == '0 && !out_valid),
    "scan state not cleared by reset")
  `SLF_ASSERT(a_result_offset, clk, rst,
    out_valid |-> (out_found ? (out_offset != '0) : (out_offset == '0)),
    "result offset inconsistent with found flag")
  `SLF_ASSERT(a_word_position_range, clk, rst,
    word_position <= LABEL_LEN_W'(LABEL_BYTES),
    "word position beyond label size")

endmodule
